### rtl/i2c_master_interrupt_transfer_assert.svh
// assertion helpers shared by the rtl files
`ifndef I2C_MASTER_INTERRUPT_TRANSFER_ASSERT_SVH
`define I2C_MASTER_INTERRUPT_TRANSFER_ASSERT_SVH

`ifndef SYNTHESIS
`define I2CMX_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("%m: assertion failed");
`define I2CMX_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("%m: forbidden condition seen");
`else
`define I2CMX_ASSERT(name, clk, rst_n, prop)
`define I2CMX_NEVER(name, clk, rst_n, cond)
`endif

`endif

### rtl/i2cmx_pkg.sv
package i2cmx_pkg;

	localparam int LEN_BITS = 16;
	// most results one item can cause (single-byte read event: address, nack, byte, close)
	localparam int NRES = 8;
	localparam int CNT_W = $clog2(NRES + 1);
	localparam int IDX_W = $clog2(NRES);

	typedef enum logic [1:0] {
		KIND_WR  = 2'd0,
		KIND_RD  = 2'd1,
		KIND_EVT = 2'd2,
		KIND_ERR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ACT_BUSY    = 3'd0,
		ACT_START   = 3'd1,
		ACT_WRITE   = 3'd2,
		ACT_STOP    = 3'd3,
		ACT_ACK     = 3'd4,
		ACT_RXBYTE  = 3'd5,
		ACT_NOTIFY  = 3'd6,
		ACT_CLRADDR = 3'd7
	} act_t;

	typedef enum logic [2:0] {
		ST_READY = 3'b001,
		ST_TX    = 3'b010,
		ST_RX    = 3'b100
	} st_t;

	localparam logic [2:0] EVC_TX_DONE = 3'd0;
	localparam logic [2:0] EVC_RX_DONE = 3'd1;
	localparam logic [2:0] EVC_BUS_ERR = 3'd2;

	localparam logic [1:0] PRI_READY = 2'd0;
	localparam logic [1:0] PRI_TX    = 2'd1;
	localparam logic [1:0] PRI_RX    = 2'd2;

	typedef struct packed {
		kind_t       kind;
		logic [6:0]  slave_addr;
		logic [15:0] length;
		logic        repeated_start;
		logic        sb;
		logic        addr;
		logic        btf;
		logic        txe;
		logic        rxne;
		logic        msl;
		logic [7:0]  data;
		logic [4:0]  err;
	} item_t;

	typedef struct packed {
		act_t       act;
		logic [7:0] data;
		logic [2:0] code;
		logic [1:0] prior;
	} ent_t;

	typedef struct packed {
		ent_t [NRES-1:0]  ent;
		logic [CNT_W-1:0] cnt;
	} bun_t;

	function automatic ent_t mk_ent(act_t act, logic [7:0] data, logic [2:0] code,
			logic [1:0] prior);
		ent_t e;
		e.act   = act;
		e.data  = data;
		e.code  = code;
		e.prior = prior;
		return e;
	endfunction

	function automatic logic [1:0] prior_code(st_t st);
		logic [1:0] p;
		unique case (st)
			ST_TX:   p = PRI_TX;
			ST_RX:   p = PRI_RX;
			default: p = PRI_READY;
		endcase
		return p;
	endfunction

endpackage

### rtl/i2c_master_interrupt_transfer.sv
// interrupt-driven i2c master transfer sequencer
// input channel (in_valid/in_stall) takes one item per transfer: a start
// request (write or read), an event interrupt with the status flags, or an
// error interrupt with the error flags. each item yields zero to eight
// result transfers on the output channel (out_valid/out_stall), the final
// one marked by last. items yielding nothing produce no output.
// the item is registered in the input register, its results are worked out
// combinationally from it and loaded into the result register, which offers
// them one after another. an item occupies the result register until its
// last result leaves; with single-result items a new item is taken every
// cycle while out_stall is low. the result register drains one entry per cycle
// while out_stall is low, and in_stall rises while it still holds undelivered
// entries and the input register is full.
// cfg_valid/cfg_ready writes the ack_control bit (always ready); write it
// only while idle.
// reset (arst_n low) clears the transfer state to ready, all interrupt
// enables off, counters and address to zero, ack_control to one, and
// drops any pending input or results.
`include "i2c_master_interrupt_transfer_assert.svh"

module i2c_master_interrupt_transfer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [6:0]  slave_addr,
	input  logic [15:0] length,
	input  logic        repeated_start,
	input  logic        flag_start_sent,
	input  logic        flag_addr_done,
	input  logic        flag_byte_done,
	input  logic        flag_tx_empty,
	input  logic        flag_rx_full,
	input  logic        flag_master,
	input  logic [7:0]  data_in,
	input  logic [4:0]  error_flags,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [7:0]  data_out,
	output logic [2:0]  event_code,
	output logic [1:0]  prior_state,
	output logic        last
);
	import i2cmx_pkg::*;

	logic             ack_ctl_q;
	logic             v_s1;
	item_t            item_s1;
	logic             bun_v_s2;
	bun_t             bun_s2;
	bun_t             bun;
	logic [IDX_W-1:0] idx_q;
	logic             ld;
	logic             fin;
	ent_t             cur;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_ctl_q <= 1'b1;
		end else if (cfg_valid) begin
			ack_ctl_q <= cfg_data;
		end
	end

	// result register frees up when empty or when its last entry leaves
	assign fin      = bun_v_s2 && !out_stall && last;
	assign ld       = v_s1 && (!bun_v_s2 || fin);
	assign in_stall = v_s1 && !ld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.kind           <= kind_t'(kind);
			item_s1.slave_addr     <= slave_addr;
			item_s1.length         <= length;
			item_s1.repeated_start <= repeated_start;
			item_s1.sb             <= flag_start_sent;
			item_s1.addr           <= flag_addr_done;
			item_s1.btf            <= flag_byte_done;
			item_s1.txe            <= flag_tx_empty;
			item_s1.rxne           <= flag_rx_full;
			item_s1.msl            <= flag_master;
			item_s1.data           <= data_in;
			item_s1.err            <= error_flags;
		end
	end

	i2cmx_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_s1),
		.ld          (ld),
		.ack_control (ack_ctl_q),
		.bun         (bun)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bun_v_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (ld) begin
			bun_v_s2 <= |bun.cnt;
			idx_q    <= '0;
		end else if (fin) begin
			bun_v_s2 <= 1'b0;
		end else if (bun_v_s2 && !out_stall) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			bun_s2 <= bun;
		end
	end

	assign cur         = bun_s2.ent[idx_q];
	assign out_valid   = bun_v_s2;
	assign action      = cur.act;
	assign data_out    = cur.data;
	assign event_code  = cur.code;
	assign prior_state = cur.prior;
	assign last        = (CNT_W'(idx_q) + CNT_W'(1)) == bun_s2.cnt;

	`I2CMX_ASSERT(a_more_follow, clk, arst_n, out_valid && !out_stall && !last |=> out_valid)
	`I2CMX_ASSERT(a_idx_in_range, clk, arst_n, bun_v_s2 |-> CNT_W'(idx_q) < bun_s2.cnt)
	`I2CMX_NEVER(a_empty_bundle, clk, arst_n, bun_v_s2 && bun_s2.cnt == '0)

endmodule

### rtl/i2cmx_core.sv
`include "i2c_master_interrupt_transfer_assert.svh"

module i2cmx_core (
	input  logic              clk,
	input  logic              arst_n,
	input  i2cmx_pkg::item_t  item,
	input  logic              ld,
	input  logic              ack_control,
	output i2cmx_pkg::bun_t   bun
);
	import i2cmx_pkg::*;

	st_t                 st_q;
	logic [LEN_BITS-1:0] tx_left_q, rx_left_q, rx_total_q;
	logic [6:0]          addr_q;
	logic                keep_q, ev_on_q, buf_on_q, err_on_q;

	st_t                 nst;
	logic [LEN_BITS-1:0] ntx, nrx, ntot;
	logic [6:0]          naddr;
	logic                nkeep, nev, nbuf, nerr;
	ent_t [NRES-1:0]     lst;
	logic [CNT_W-1:0]    cnt;

	always_comb begin
		nst   = st_q;
		ntx   = tx_left_q;
		nrx   = rx_left_q;
		ntot  = rx_total_q;
		naddr = addr_q;
		nkeep = keep_q;
		nev   = ev_on_q;
		nbuf  = buf_on_q;
		nerr  = err_on_q;
		lst   = '0;
		cnt   = '0;
		unique case (item.kind)
			KIND_WR, KIND_RD: begin
				if (st_q == ST_READY) begin
					naddr = item.slave_addr;
					nkeep = item.repeated_start;
					if (item.kind == KIND_RD) begin
						nrx  = LEN_BITS'(item.length);
						ntot = LEN_BITS'(item.length);
						nst  = ST_RX;
					end else begin
						ntx = LEN_BITS'(item.length);
						nst = ST_TX;
					end
					nev  = 1'b1;
					nbuf = 1'b1;
					nerr = 1'b1;
					lst[cnt[IDX_W-1:0]] = mk_ent(ACT_START, 8'd0, 3'd0, 2'd0);
					cnt = cnt + CNT_W'(1);
				end
				lst[cnt[IDX_W-1:0]] = mk_ent(ACT_BUSY, 8'd0, 3'd0, prior_code(st_q));
				cnt = cnt + CNT_W'(1);
			end
			KIND_EVT: begin
				if (ev_on_q) begin
					if (item.sb && st_q != ST_READY) begin
						lst[cnt[IDX_W-1:0]] = mk_ent(ACT_WRITE, {addr_q, st_q == ST_RX},
							3'd0, 2'd0);
						cnt = cnt + CNT_W'(1);
					end
					if (item.addr) begin
						// single byte read: nack and stop before addr is cleared
						if (item.msl && st_q == ST_RX && rx_total_q == LEN_BITS'(1)) begin
							lst[cnt[IDX_W-1:0]] = mk_ent(ACT_ACK, 8'd0, 3'd0, 2'd0);
							cnt = cnt + CNT_W'(1);
							lst[cnt[IDX_W-1:0]] = mk_ent(ACT_STOP, 8'd0, 3'd0, 2'd0);
							cnt = cnt + CNT_W'(1);
						end
						lst[cnt[IDX_W-1:0]] = mk_ent(ACT_CLRADDR, 8'd0, 3'd0, 2'd0);
						cnt = cnt + CNT_W'(1);
					end
					if (item.btf && st_q == ST_TX && item.txe && tx_left_q == '0) begin
						if (!keep_q) begin
							lst[cnt[IDX_W-1:0]] = mk_ent(ACT_STOP, 8'd0, 3'd0, 2'd0);
							cnt = cnt + CNT_W'(1);
						end
						nev  = 1'b0;
						nbuf = 1'b0;
						nst  = ST_READY;
						lst[cnt[IDX_W-1:0]] = mk_ent(ACT_NOTIFY, 8'd0, EVC_TX_DONE, 2'd0);
						cnt = cnt + CNT_W'(1);
					end
					// buffer enable is the value seen at entry, state is the updated one
					if (buf_on_q && item.txe && item.msl && nst == ST_TX && ntx != '0) begin
						lst[cnt[IDX_W-1:0]] = mk_ent(ACT_WRITE, item.data, 3'd0, 2'd0);
						cnt = cnt + CNT_W'(1);
						ntx = ntx - LEN_BITS'(1);
					end
					if (buf_on_q && item.rxne && item.msl && nst == ST_RX) begin
						if (ntot == LEN_BITS'(1)) begin
							lst[cnt[IDX_W-1:0]] = mk_ent(ACT_RXBYTE, item.data, 3'd0, 2'd0);
							cnt = cnt + CNT_W'(1);
							nrx = nrx - LEN_BITS'(1);
						end else if (ntot > LEN_BITS'(1)) begin
							if (nrx == LEN_BITS'(2)) begin
								lst[cnt[IDX_W-1:0]] = mk_ent(ACT_ACK, 8'd0, 3'd0, 2'd0);
								cnt = cnt + CNT_W'(1);
								lst[cnt[IDX_W-1:0]] = mk_ent(ACT_STOP, 8'd0, 3'd0, 2'd0);
								cnt = cnt + CNT_W'(1);
							end
							lst[cnt[IDX_W-1:0]] = mk_ent(ACT_RXBYTE, item.data, 3'd0, 2'd0);
							cnt = cnt + CNT_W'(1);
							nrx = nrx - LEN_BITS'(1);
						end
						if (nrx == '0) begin
							if (!keep_q) begin
								lst[cnt[IDX_W-1:0]] = mk_ent(ACT_STOP, 8'd0, 3'd0, 2'd0);
								cnt = cnt + CNT_W'(1);
							end
							nev  = 1'b0;
							nbuf = 1'b0;
							nst  = ST_READY;
							ntot = '0;
							if (ack_control) begin
								lst[cnt[IDX_W-1:0]] = mk_ent(ACT_ACK, 8'd1, 3'd0, 2'd0);
								cnt = cnt + CNT_W'(1);
							end
							lst[cnt[IDX_W-1:0]] = mk_ent(ACT_NOTIFY, 8'd0, EVC_RX_DONE,
								2'd0);
							cnt = cnt + CNT_W'(1);
						end
					end
				end
			end
			KIND_ERR: begin
				if (err_on_q) begin
					for (int i = 0; i < 5; i++) begin
						if (item.err[i]) begin
							lst[cnt[IDX_W-1:0]] = mk_ent(ACT_NOTIFY, 8'd0,
								3'(EVC_BUS_ERR + 3'(i)), 2'd0);
							cnt = cnt + CNT_W'(1);
						end
					end
				end
			end
			default: ;
		endcase
		bun.ent = lst;
		bun.cnt = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_READY;
			tx_left_q  <= '0;
			rx_left_q  <= '0;
			rx_total_q <= '0;
			addr_q     <= '0;
			keep_q     <= 1'b0;
			ev_on_q    <= 1'b0;
			buf_on_q   <= 1'b0;
			err_on_q   <= 1'b0;
		end else if (ld) begin
			st_q       <= nst;
			tx_left_q  <= ntx;
			rx_left_q  <= nrx;
			rx_total_q <= ntot;
			addr_q     <= naddr;
			keep_q     <= nkeep;
			ev_on_q    <= nev;
			buf_on_q   <= nbuf;
			err_on_q   <= nerr;
		end
	end

	`I2CMX_NEVER(a_busy_needs_irq, clk, arst_n, st_q != ST_READY && !(ev_on_q && buf_on_q && err_on_q))
	`I2CMX_ASSERT(a_err_irq_sticky, clk, arst_n, ev_on_q |-> err_on_q)
	`I2CMX_ASSERT(a_rx_within_total, clk, arst_n, rx_left_q <= rx_total_q)

endmodule

### tb/testbench.sv
module testbench;
	import i2cmx_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int STUCK_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 10;

	typedef struct {
		kind_t       kind;
		logic [6:0]  addr;
		logic [15:0] len;
		logic        rs;
		logic        sb;
		logic        ad;
		logic        btf;
		logic        txe;
		logic        rxne;
		logic        msl;
		logic [7:0]  data;
		logic [4:0]  err;
		logic        drain;
	} stim_t;

	typedef struct {
		act_t       act;
		logic [7:0] data;
		logic [2:0] code;
		logic [1:0] prior;
		logic       last;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b1;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = KIND_EVT;
	logic [6:0]  slave_addr = '0;
	logic [15:0] length = '0;
	logic        repeated_start = 1'b0;
	logic        flag_start_sent = 1'b0;
	logic        flag_addr_done = 1'b0;
	logic        flag_byte_done = 1'b0;
	logic        flag_tx_empty = 1'b0;
	logic        flag_rx_full = 1'b0;
	logic        flag_master = 1'b0;
	logic [7:0]  data_in = '0;
	logic [4:0]  error_flags = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  action;
	logic [7:0]  data_out;
	logic [2:0]  event_code;
	logic [1:0]  prior_state;
	logic        last;

	i2c_master_interrupt_transfer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.slave_addr(slave_addr),
		.length(length),
		.repeated_start(repeated_start),
		.flag_start_sent(flag_start_sent),
		.flag_addr_done(flag_addr_done),
		.flag_byte_done(flag_byte_done),
		.flag_tx_empty(flag_tx_empty),
		.flag_rx_full(flag_rx_full),
		.flag_master(flag_master),
		.data_in(data_in),
		.error_flags(error_flags),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.action(action),
		.data_out(data_out),
		.event_code(event_code),
		.prior_state(prior_state),
		.last(last)
	);

	stim_t   item_q[$];
	result_t expected_actions[$];
	result_t step_actions[$];
	int      queued = 0;
	int      mismatches = 0;
	int      send_idle_pct = 31;
	int      recv_idle_pct = 60;
	int      stuck_cycles = 0;
	int      hold_left = 0;
	logic    hold_go = 1'b0;
	logic    hold_done = 1'b0;
	logic    results_drained = 1'b1;

	// sequencer shadow state
	logic        ack_ctl = 1'b1;
	logic [1:0]  xfer_st = PRI_READY;
	logic [15:0] tx_left = '0;
	logic [15:0] rx_left = '0;
	logic [15:0] rx_total = '0;
	logic [6:0]  target = '0;
	logic        keep_bus = 1'b0;
	logic        ev_on = 1'b0;
	logic        buf_on = 1'b0;
	logic        err_on = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void add_action(act_t a, logic [7:0] d, logic [2:0] c, logic [1:0] p);
		result_t r;
		r.act = a;
		r.data = d;
		r.code = c;
		r.prior = p;
		r.last = 1'b0;
		if (step_actions.size() < 12)
			step_actions.push_back(r);
	endfunction

	function automatic void drop_ack();
		add_action(ACT_ACK, 8'd0, 3'd0, PRI_READY);
		add_action(ACT_STOP, 8'd0, 3'd0, PRI_READY);
	endfunction

	function automatic void finish_xfer(logic [2:0] code);
		if (!keep_bus)
			add_action(ACT_STOP, 8'd0, 3'd0, PRI_READY);
		ev_on = 1'b0;
		buf_on = 1'b0;
		xfer_st = PRI_READY;
		if (code == EVC_RX_DONE && ack_ctl)
			add_action(ACT_ACK, 8'd1, 3'd0, PRI_READY);
		add_action(ACT_NOTIFY, 8'd0, code, PRI_READY);
	endfunction

	// works out the actions one accepted transfer causes and queues them
	function automatic void predict_actions(stim_t it);
		logic [1:0] prior;
		logic ev_en;
		logic buf_en;
		step_actions.delete();
		case (it.kind)
			KIND_WR, KIND_RD: begin
				prior = xfer_st;
				if (prior == PRI_READY) begin
					target = it.addr;
					keep_bus = it.rs;
					if (it.kind == KIND_RD) begin
						rx_left = it.len;
						rx_total = it.len;
						xfer_st = PRI_RX;
					end else begin
						tx_left = it.len;
						xfer_st = PRI_TX;
					end
					ev_on = 1'b1;
					buf_on = 1'b1;
					err_on = 1'b1;
					add_action(ACT_START, 8'd0, 3'd0, PRI_READY);
				end
				add_action(ACT_BUSY, 8'd0, 3'd0, prior);
			end
			KIND_EVT: begin
				// enables are sampled once per event
				ev_en = ev_on;
				buf_en = buf_on;
				if (ev_en) begin
					if (it.sb && xfer_st == PRI_TX)
						add_action(ACT_WRITE, {target, 1'b0}, 3'd0, PRI_READY);
					else if (it.sb && xfer_st == PRI_RX)
						add_action(ACT_WRITE, {target, 1'b1}, 3'd0, PRI_READY);
					if (it.ad) begin
						if (it.msl && xfer_st == PRI_RX && rx_total == 16'd1)
							drop_ack();
						add_action(ACT_CLRADDR, 8'd0, 3'd0, PRI_READY);
					end
					if (it.btf && xfer_st == PRI_TX && it.txe && tx_left == 16'd0)
						finish_xfer(EVC_TX_DONE);
					if (buf_en && it.txe && it.msl && xfer_st == PRI_TX && tx_left != 16'd0) begin
						add_action(ACT_WRITE, it.data, 3'd0, PRI_READY);
						tx_left = tx_left - 16'd1;
					end
					if (buf_en && it.rxne && it.msl && xfer_st == PRI_RX) begin
						if (rx_total == 16'd1) begin
							add_action(ACT_RXBYTE, it.data, 3'd0, PRI_READY);
							rx_left = rx_left - 16'd1;
						end
						if (rx_total > 16'd1) begin
							if (rx_left == 16'd2)
								drop_ack();
							add_action(ACT_RXBYTE, it.data, 3'd0, PRI_READY);
							rx_left = rx_left - 16'd1;
						end
						if (rx_left == 16'd0) begin
							rx_total = '0;
							finish_xfer(EVC_RX_DONE);
						end
					end
				end
			end
			default: begin
				if (err_on) begin
					for (int i = 0; i < 5; i++)
						if (it.err[i])
							add_action(ACT_NOTIFY, 8'd0, EVC_BUS_ERR + 3'(i), PRI_READY);
				end
			end
		endcase
		if (step_actions.size() > 0)
			step_actions[step_actions.size() - 1].last = 1'b1;
		foreach (step_actions[i])
			expected_actions.push_back(step_actions[i]);
	endfunction

	function automatic stim_t any_item();
		stim_t s;
		s.kind = kind_t'($urandom_range(3));
		s.addr = 7'($urandom);
		s.len = 16'($urandom);
		s.rs = 1'($urandom_range(1));
		s.sb = 1'($urandom_range(1));
		s.ad = 1'($urandom_range(1));
		s.btf = 1'($urandom_range(1));
		s.txe = 1'($urandom_range(1));
		s.rxne = 1'($urandom_range(1));
		s.msl = 1'($urandom_range(1));
		s.data = 8'($urandom);
		s.err = 5'($urandom);
		s.drain = 1'b0;
		return s;
	endfunction

	function automatic stim_t start_item(kind_t k, logic [6:0] a, logic [15:0] n, logic rs);
		stim_t s;
		s = any_item();
		s.kind = k;
		s.addr = a;
		s.len = n;
		s.rs = rs;
		return s;
	endfunction

	function automatic stim_t ev_item(logic sb, logic ad, logic btf, logic txe, logic rxne,
			logic msl, logic [7:0] d);
		stim_t s;
		s = any_item();
		s.kind = KIND_EVT;
		s.sb = sb;
		s.ad = ad;
		s.btf = btf;
		s.txe = txe;
		s.rxne = rxne;
		s.msl = msl;
		s.data = d;
		return s;
	endfunction

	function automatic stim_t err_item(logic [4:0] e);
		stim_t s;
		s = any_item();
		s.kind = KIND_ERR;
		s.err = e;
		return s;
	endfunction

	function automatic void queue_item(stim_t s);
		item_q.push_back(s);
		queued++;
	endfunction

	// one well-formed transfer with random content, completed to the end
	function automatic void queue_xfer(logic hold_first);
		logic rd;
		logic [15:0] n;
		stim_t s;
		rd = 1'($urandom_range(1));
		n = ($urandom_range(9) == 0) ? 16'($urandom_range(20, 6)) : 16'($urandom_range(5));
		s = start_item(rd ? KIND_RD : KIND_WR, 7'($urandom), n, 1'($urandom_range(1)));
		s.drain = hold_first;
		queue_item(s);
		if ($urandom_range(5) == 0)
			queue_item(start_item(kind_t'($urandom_range(1)), 7'($urandom), 16'($urandom),
				1'($urandom)));
		if ($urandom_range(3) == 0) begin
			queue_item(ev_item(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'($urandom)));
		end else begin
			queue_item(ev_item(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'($urandom_range(1)),
				8'($urandom)));
			queue_item(ev_item(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'($urandom)));
		end
		for (int i = 0; i < n; i++) begin
			if (rd)
				queue_item(ev_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'($urandom)));
			else
				queue_item(ev_item(1'b0, 1'b0, 1'($urandom_range(1)), 1'b1, 1'b0, 1'b1,
					8'($urandom)));
			if ($urandom_range(9) == 0)
				queue_item(err_item(5'($urandom)));
		end
		if (!rd)
			queue_item(ev_item(1'b0, 1'b0, 1'b1, 1'b1, 1'($urandom_range(1)), 1'b1,
				8'($urandom)));
		else if (n == 16'd0)
			queue_item(ev_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'($urandom)));
	endfunction

	function automatic void queue_random(int n, int hold_pct);
		int goal;
		stim_t s;
		goal = queued + n;
		while (queued < goal) begin
			case ($urandom_range(9))
				0: queue_item(err_item(5'($urandom)));
				1: begin
					// noise between transfers, event enables are off here
					s = any_item();
					s.kind = kind_t'($urandom_range(3, 2));
					queue_item(s);
				end
				default: queue_xfer($urandom_range(99) < hold_pct);
			endcase
		end
	endfunction

	function automatic void queue_directed();
		stim_t s;
		queue_item(ev_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hff));
		queue_item(err_item(5'h1f));
		// zero-length write, then a start while busy
		queue_item(start_item(KIND_WR, 7'h7f, 16'd0, 1'b0));
		queue_item(start_item(KIND_RD, 7'h00, 16'hffff, 1'b1));
		queue_item(ev_item(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
		queue_item(ev_item(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
		queue_item(ev_item(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'ha5));
		queue_item(err_item(5'h1f));
		// single-byte read keeping the bus
		queue_item(start_item(KIND_RD, 7'h00, 16'd1, 1'b1));
		queue_item(start_item(KIND_WR, 7'h7f, 16'hffff, 1'b0));
		queue_item(ev_item(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
		queue_item(ev_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'hff));
		// three-byte read, ack dropped on the second byte
		queue_item(start_item(KIND_RD, 7'h55, 16'd3, 1'b0));
		queue_item(ev_item(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
		queue_item(ev_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h01));
		queue_item(ev_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h80));
		queue_item(ev_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'hfe));
		// zero-length read closes on the first rxne
		queue_item(start_item(KIND_RD, 7'h2a, 16'd0, 1'b0));
		queue_item(ev_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h33));
		// two-byte write, sent only after everything has drained
		s = start_item(KIND_WR, 7'h01, 16'd2, 1'b1);
		s.drain = 1'b1;
		queue_item(s);
		queue_item(ev_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00));
		queue_item(ev_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 8'hff));
		queue_item(ev_item(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h5a));
		queue_item(ev_item(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'h5a));
		queue_item(err_item(5'h15));
	endfunction

	task automatic wait_idle();
		do
			@(negedge clk);
		while (item_q.size() != 0 || in_valid || expected_actions.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_ack_ctl(input logic v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		ack_ctl = v;
	endtask

	always @(negedge clk)
		results_drained = (expected_actions.size() == 0);

	// driver
	always @(posedge clk) begin
		logic nv;
		stim_t nx;
		if (arst_n) begin
			nv = in_valid;
			if (in_valid && !in_stall) begin
				predict_actions(nx);
				nv = 1'b0;
			end
			if (!nv && item_q.size() != 0 && $urandom_range(99) >= send_idle_pct
					&& (!item_q[0].drain || (results_drained && !in_valid))) begin
				nx = item_q.pop_front();
				nv = 1'b1;
				kind <= nx.kind;
				slave_addr <= nx.addr;
				length <= nx.len;
				repeated_start <= nx.rs;
				flag_start_sent <= nx.sb;
				flag_addr_done <= nx.ad;
				flag_byte_done <= nx.btf;
				flag_tx_empty <= nx.txe;
				flag_rx_full <= nx.rxne;
				flag_master <= nx.msl;
				data_in <= nx.data;
				error_flags <= nx.err;
			end
			in_valid <= nv;
		end
	end

	function automatic void check_field(string name, int unsigned e, int unsigned a);
		if (e !== a) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, e, a);
			mismatches++;
		end
	endfunction

	// monitor
	always @(posedge clk) begin
		logic st;
		result_t exp_r;
		if (arst_n) begin
			if (out_valid === 1'b1 && !out_stall) begin
				if (expected_actions.size() == 0) begin
					$error("unexpected result transfer: action 0x%0h", action);
					mismatches++;
				end else begin
					exp_r = expected_actions.pop_front();
					check_field("action", exp_r.act, action);
					check_field("data_out", exp_r.data, data_out);
					check_field("event_code", exp_r.code, event_code);
					check_field("prior_state", exp_r.prior, prior_state);
					check_field("last", exp_r.last, last);
				end
			end
			if (hold_go && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				st = 1'b1;
				hold_left--;
			end else begin
				st = ($urandom_range(99) < recv_idle_pct);
			end
			out_stall <= st;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)
				|| (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		wait (stuck_cycles >= STUCK_LIMIT);
		$display("i2c_master_interrupt_transfer regression: fail");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		write_ack_ctl(1'b1);
		send_idle_pct = 31;
		recv_idle_pct = 60;
		queue_directed();
		queue_random(70, 5);
		wait_idle();
		write_ack_ctl(1'b0);
		queue_random(70, 5);
		wait_idle();
		write_ack_ctl(1'b1);
		send_idle_pct = 60;
		recv_idle_pct = 31;
		queue_random(115, 10);
		wait_idle();
		write_ack_ctl(1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(115, 0);
		// long receiver hold while the sender keeps offering items
		@(negedge clk);
		hold_go = 1'b1;
		wait_idle();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && expected_actions.size() == 0)
			$display("i2c_master_interrupt_transfer regression: pass");
		else
			$display("i2c_master_interrupt_transfer regression: fail");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/i2cmx_pkg.sv
rtl/i2cmx_core.sv
rtl/i2c_master_interrupt_transfer.sv
tb/testbench.sv
